// ===== rtl/core/hnms_pkg.sv =====
// shared types and constants for the hard non-max suppression core
package hnms_pkg;

	localparam logic [33:0] IOU_EPS = 34'd42950;

	localparam logic [15:0] IOU_THR_RESET = 16'd19661;
	localparam logic [6:0]  TOP_K_RESET   = 7'd10;
	localparam logic [6:0]  CAND_RESET    = 7'd64;

	localparam logic [1:0] CFG_IOU_THR = 2'd0;
	localparam logic [1:0] CFG_TOP_K   = 2'd1;
	localparam logic [1:0] CFG_CAND    = 2'd2;

	typedef enum logic [3:0] {
		S_LOAD,
		S_R_I,
		S_R_IW,
		S_R_J,
		S_R_JW,
		S_R_W,
		S_P_SET,
		S_P_SCAN,
		S_P_RK,
		S_P_RKW,
		S_P_BXW,
		S_Q_SCAN,
		S_Q_RK,
		S_Q_RKW,
		S_Q_BXW,
		S_Q_IOU
	} state_t;

	typedef enum logic [2:0] {
		I_IDLE,
		I_OV,
		I_AA,
		I_AB,
		I_DEN,
		I_CMP
	} iou_step_t;

endpackage

// ===== rtl/core/hnms_mem.sv =====
// box, score and rank storage with registered reads
module hnms_mem #(
	parameter int IW = 6
) (
	input  logic          clk,
	input  logic          box_we,
	input  logic [IW-1:0] box_waddr,
	input  logic [63:0]   box_wdata,
	input  logic [15:0]   score_wdata,
	input  logic [IW-1:0] box_raddr,
	output logic [63:0]   box_rdata,
	output logic [15:0]   score_rdata,
	input  logic          rank_we,
	input  logic [IW-1:0] rank_waddr,
	input  logic [IW-1:0] rank_wdata,
	input  logic [IW-1:0] rank_raddr,
	output logic [IW-1:0] rank_rdata
);

	localparam int DEPTH = 1 << IW;

	logic [63:0]   box_mem   [DEPTH];
	logic [15:0]   score_mem [DEPTH];
	logic [IW-1:0] rank_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (box_we) begin
			box_mem[box_waddr]   <= box_wdata;
			score_mem[box_waddr] <= score_wdata;
		end
		box_rdata   <= box_mem[box_raddr];
		score_rdata <= score_mem[box_raddr];
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
		rank_rdata <= rank_mem[rank_raddr];
	end

endmodule

// ===== rtl/core/hnms_iou.sv =====
// iou threshold test on one shared multiplier, five steps per pair
module hnms_iou (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a_box,
	input  logic [63:0] b_box,
	input  logic [15:0] thr,
	output logic        done,
	output logic        drop
);

	hnms_pkg::iou_step_t step_q;
	logic [15:0] ow_q, oh_q, aw_q, ah_q, bw_q, bh_q;
	logic [31:0] ov_q, aa_q, ab_q;
	logic [33:0] den_q;
	logic [15:0] mul_a;
	logic [33:0] mul_b;
	logic [49:0] prod;
	logic        done_q, drop_q;

	function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
		span = (hi > lo) ? (hi - lo) : 16'd0;
	endfunction

	function automatic logic [15:0] vmax(input logic [15:0] x, input logic [15:0] y);
		vmax = (x > y) ? x : y;
	endfunction

	function automatic logic [15:0] vmin(input logic [15:0] x, input logic [15:0] y);
		vmin = (x < y) ? x : y;
	endfunction

	always_comb begin
		mul_a = 16'd0;
		mul_b = 34'd0;
		case (step_q)
			hnms_pkg::I_OV: begin
				mul_a = ow_q;
				mul_b = {18'd0, oh_q};
			end
			hnms_pkg::I_AA: begin
				mul_a = aw_q;
				mul_b = {18'd0, ah_q};
			end
			hnms_pkg::I_AB: begin
				mul_a = bw_q;
				mul_b = {18'd0, bh_q};
			end
			hnms_pkg::I_CMP: begin
				mul_a = thr;
				mul_b = den_q;
			end
			default: begin
				mul_a = 16'd0;
				mul_b = 34'd0;
			end
		endcase
	end

	assign prod = {34'd0, mul_a} * {16'd0, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= hnms_pkg::I_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (step_q)
				hnms_pkg::I_IDLE: if (start) step_q <= hnms_pkg::I_OV;
				hnms_pkg::I_OV:   step_q <= hnms_pkg::I_AA;
				hnms_pkg::I_AA:   step_q <= hnms_pkg::I_AB;
				hnms_pkg::I_AB:   step_q <= hnms_pkg::I_DEN;
				hnms_pkg::I_DEN:  step_q <= hnms_pkg::I_CMP;
				hnms_pkg::I_CMP: begin
					step_q <= hnms_pkg::I_IDLE;
					done_q <= 1'b1;
				end
				default: step_q <= hnms_pkg::I_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (step_q)
			hnms_pkg::I_IDLE: begin
				ow_q <= span(vmax(a_box[15:0], b_box[15:0]), vmin(a_box[47:32], b_box[47:32]));
				oh_q <= span(vmax(a_box[31:16], b_box[31:16]), vmin(a_box[63:48], b_box[63:48]));
				aw_q <= span(a_box[15:0], a_box[47:32]);
				ah_q <= span(a_box[31:16], a_box[63:48]);
				bw_q <= span(b_box[15:0], b_box[47:32]);
				bh_q <= span(b_box[31:16], b_box[63:48]);
			end
			hnms_pkg::I_OV:  ov_q <= prod[31:0];
			hnms_pkg::I_AA:  aa_q <= prod[31:0];
			hnms_pkg::I_AB:  ab_q <= prod[31:0];
			hnms_pkg::I_DEN: den_q <= {2'd0, aa_q} + {2'd0, ab_q} - {2'd0, ov_q}
				+ hnms_pkg::IOU_EPS;
			hnms_pkg::I_CMP: drop_q <= {2'd0, ov_q, 16'd0} > prod;
			default: ;
		endcase
	end

	assign done = done_q;
	assign drop = drop_q;

endmodule

// ===== rtl/core/hard_non_max_suppression_core.sv =====
// top level of the hard non-max suppression core: load, rank, suppress, emit
// Boxes are requested one per cycle with start while busy is low; the request
// with last_box set closes the set and raises busy until every kept box has been
// shown. Each kept box appears for one cycle with result_valid and cannot be held
// off; the final one carries last_pick, and a set with no candidates shows none.
// Ranking counts, for each of the n stored boxes, how many others outrank it on
// one score comparator. Suppression then tests each remaining candidate against
// each pick on one shared multiplier. Config writes are always ready.
module hard_non_max_suppression_core #(
	parameter int MAX_BOXES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] left,
	input  logic [15:0] top,
	input  logic [15:0] right,
	input  logic [15:0] bottom,
	input  logic [15:0] score,
	input  logic        last_box,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output logic [5:0]  box_index,
	output logic [15:0] out_left,
	output logic [15:0] out_top,
	output logic [15:0] out_right,
	output logic [15:0] out_bottom,
	output logic [15:0] out_score,
	output logic        last_pick
);

	localparam int IW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BOXES);

	hnms_pkg::state_t state_q, state_d;

	logic [15:0] thr_q;
	logic [6:0]  top_k_q, cand_lim_q;
	logic [CW-1:0] count_q, n_q, cands_q, i_q, j_q, cnt_q;
	logic [6:0]  picks_q;
	logic [MAX_BOXES-1:0] alive_q;
	logic [15:0] si_q;
	logic [IW-1:0] cur_q;
	logic        pend_v_q;
	logic [63:0] pend_box_q;
	logic [15:0] pend_score_q;
	logic [IW-1:0] pend_idx_q;

	logic        res_v_q, res_last_q;
	logic [IW-1:0] res_idx_q;
	logic [63:0] res_box_q;
	logic [15:0] res_score_q;

	logic          box_we, rank_we;
	logic [IW-1:0] box_raddr, rank_raddr;
	logic [63:0]   box_rd;
	logic [15:0]   score_rd;
	logic [IW-1:0] rank_rd;
	logic          accept;
	logic          beats;
	logic [6:0]    cands_w;
	logic          iou_start, iou_done, iou_drop;

	assign accept = start && !busy;
	assign busy = (state_q != hnms_pkg::S_LOAD);
	assign cfg_ready = 1'b1;
	assign beats = (score_rd > si_q) || ((score_rd == si_q) && (j_q < i_q));
	assign cands_w = (cand_lim_q < 7'(n_q)) ? cand_lim_q : 7'(n_q);

	hnms_mem #(.IW(IW)) u_mem (
		.clk         (clk),
		.box_we      (box_we),
		.box_waddr   (count_q[IW-1:0]),
		.box_wdata   ({bottom, right, top, left}),
		.score_wdata (score),
		.box_raddr   (box_raddr),
		.box_rdata   (box_rd),
		.score_rdata (score_rd),
		.rank_we     (rank_we),
		.rank_waddr  (cnt_q[IW-1:0]),
		.rank_wdata  (i_q[IW-1:0]),
		.rank_raddr  (rank_raddr),
		.rank_rdata  (rank_rd)
	);

	hnms_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (iou_start),
		.a_box  (pend_box_q),
		.b_box  (box_rd),
		.thr    (thr_q),
		.done   (iou_done),
		.drop   (iou_drop)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			hnms_pkg::S_LOAD:   if (accept && last_box) state_d = hnms_pkg::S_R_I;
			hnms_pkg::S_R_I:    state_d = hnms_pkg::S_R_IW;
			hnms_pkg::S_R_IW:   state_d = hnms_pkg::S_R_J;
			hnms_pkg::S_R_J:    state_d = hnms_pkg::S_R_JW;
			hnms_pkg::S_R_JW:   state_d = (j_q + 1'b1 == n_q) ? hnms_pkg::S_R_W : hnms_pkg::S_R_J;
			hnms_pkg::S_R_W:    state_d = (i_q + 1'b1 == n_q) ? hnms_pkg::S_P_SET : hnms_pkg::S_R_I;
			hnms_pkg::S_P_SET:  state_d = hnms_pkg::S_P_SCAN;
			hnms_pkg::S_P_SCAN: begin
				if (i_q == cands_q) begin
					state_d = hnms_pkg::S_LOAD;
				end else if (!alive_q[i_q[IW-1:0]]) begin
					state_d = hnms_pkg::S_P_SCAN;
				end else if (top_k_q != 7'd0 && picks_q >= top_k_q) begin
					state_d = hnms_pkg::S_LOAD;
				end else begin
					state_d = hnms_pkg::S_P_RK;
				end
			end
			hnms_pkg::S_P_RK:   state_d = hnms_pkg::S_P_RKW;
			hnms_pkg::S_P_RKW:  state_d = hnms_pkg::S_P_BXW;
			hnms_pkg::S_P_BXW:  state_d = hnms_pkg::S_Q_SCAN;
			hnms_pkg::S_Q_SCAN: begin
				if (j_q >= cands_q) begin
					state_d = hnms_pkg::S_P_SCAN;
				end else if (!alive_q[j_q[IW-1:0]]) begin
					state_d = hnms_pkg::S_Q_SCAN;
				end else begin
					state_d = hnms_pkg::S_Q_RK;
				end
			end
			hnms_pkg::S_Q_RK:   state_d = hnms_pkg::S_Q_RKW;
			hnms_pkg::S_Q_RKW:  state_d = hnms_pkg::S_Q_BXW;
			hnms_pkg::S_Q_BXW:  state_d = hnms_pkg::S_Q_IOU;
			hnms_pkg::S_Q_IOU:  if (iou_done) state_d = hnms_pkg::S_Q_SCAN;
			default:            state_d = hnms_pkg::S_LOAD;
		endcase
	end

	always_comb begin
		box_we     = 1'b0;
		rank_we    = 1'b0;
		box_raddr  = i_q[IW-1:0];
		rank_raddr = i_q[IW-1:0];
		iou_start  = 1'b0;
		case (state_q)
			hnms_pkg::S_LOAD:  box_we = accept && (count_q < MAXC);
			hnms_pkg::S_R_I:   box_raddr = i_q[IW-1:0];
			hnms_pkg::S_R_J:   box_raddr = j_q[IW-1:0];
			hnms_pkg::S_R_W:   rank_we = 1'b1;
			hnms_pkg::S_P_RK:  rank_raddr = i_q[IW-1:0];
			hnms_pkg::S_P_RKW: box_raddr = rank_rd;
			hnms_pkg::S_Q_RK:  rank_raddr = j_q[IW-1:0];
			hnms_pkg::S_Q_RKW: box_raddr = rank_rd;
			hnms_pkg::S_Q_BXW: iou_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hnms_pkg::S_LOAD;
			thr_q        <= hnms_pkg::IOU_THR_RESET;
			top_k_q      <= hnms_pkg::TOP_K_RESET;
			cand_lim_q   <= hnms_pkg::CAND_RESET;
			count_q      <= '0;
			n_q          <= '0;
			cands_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			cnt_q        <= '0;
			si_q         <= '0;
			cur_q        <= '0;
			alive_q      <= '0;
			picks_q      <= '0;
			pend_v_q     <= 1'b0;
			pend_box_q   <= '0;
			pend_score_q <= '0;
			pend_idx_q   <= '0;
			res_v_q      <= 1'b0;
			res_last_q   <= 1'b0;
			res_idx_q    <= '0;
			res_box_q    <= '0;
			res_score_q  <= '0;
		end else begin
			state_q <= state_d;
			res_v_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					hnms_pkg::CFG_IOU_THR: thr_q <= cfg_data;
					hnms_pkg::CFG_TOP_K:   top_k_q <= cfg_data[6:0];
					hnms_pkg::CFG_CAND:    cand_lim_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			case (state_q)
				hnms_pkg::S_LOAD: begin
					if (accept) begin
						if (count_q < MAXC) count_q <= count_q + 1'b1;
						n_q <= (count_q < MAXC) ? count_q + 1'b1 : count_q;
						i_q <= '0;
					end
				end
				hnms_pkg::S_R_I: begin
					j_q   <= '0;
					cnt_q <= '0;
				end
				hnms_pkg::S_R_IW: si_q <= score_rd;
				hnms_pkg::S_R_JW: begin
					if (beats) cnt_q <= cnt_q + 1'b1;
					j_q <= j_q + 1'b1;
				end
				hnms_pkg::S_R_W: i_q <= i_q + 1'b1;
				hnms_pkg::S_P_SET: begin
					cands_q <= CW'(cands_w);
					for (int k = 0; k < MAX_BOXES; k++) begin
						alive_q[k] <= (k < int'(cands_w));
					end
					picks_q  <= '0;
					i_q      <= '0;
					pend_v_q <= 1'b0;
				end
				hnms_pkg::S_P_SCAN: begin
					if (i_q == cands_q || (alive_q[i_q[IW-1:0]] && top_k_q != 7'd0
						&& picks_q >= top_k_q)) begin
						res_v_q    <= pend_v_q;
						res_last_q <= 1'b1;
						res_idx_q  <= pend_idx_q;
						res_box_q  <= pend_box_q;
						res_score_q <= pend_score_q;
						pend_v_q   <= 1'b0;
						count_q    <= '0;
						alive_q    <= '0;
						picks_q    <= '0;
					end else if (!alive_q[i_q[IW-1:0]]) begin
						i_q <= i_q + 1'b1;
					end
				end
				hnms_pkg::S_P_RKW: cur_q <= rank_rd;
				hnms_pkg::S_P_BXW: begin
					res_v_q     <= pend_v_q;
					res_last_q  <= 1'b0;
					res_idx_q   <= pend_idx_q;
					res_box_q   <= pend_box_q;
					res_score_q <= pend_score_q;
					pend_v_q     <= 1'b1;
					pend_idx_q   <= cur_q;
					pend_box_q   <= box_rd;
					pend_score_q <= score_rd;
					alive_q[i_q[IW-1:0]] <= 1'b0;
					picks_q <= picks_q + 1'b1;
					j_q     <= i_q + 1'b1;
				end
				hnms_pkg::S_Q_SCAN: begin
					if (j_q >= cands_q) begin
						i_q <= i_q + 1'b1;
					end else if (!alive_q[j_q[IW-1:0]]) begin
						j_q <= j_q + 1'b1;
					end
				end
				hnms_pkg::S_Q_IOU: begin
					if (iou_done) begin
						if (iou_drop) alive_q[j_q[IW-1:0]] <= 1'b0;
						j_q <= j_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign result_valid = res_v_q;
	assign last_pick    = res_v_q && res_last_q;
	assign box_index    = 6'(res_idx_q);
	assign out_left     = res_box_q[15:0];
	assign out_top      = res_box_q[31:16];
	assign out_right    = res_box_q[47:32];
	assign out_bottom   = res_box_q[63:48];
	assign out_score    = res_score_q;

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last_pick |=> !result_valid)
		else $error("result after final pick");
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result while idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_box |=> !busy)
		else $error("busy after plain load");
	a_iou_drop: assert property (@(posedge clk) disable iff (!arst_n)
		iou_done |-> state_q == hnms_pkg::S_Q_IOU)
		else $error("iou result outside compare");

endmodule

// ===== bench/hnms_checker.sv =====
// checker for the hard non-max suppression core: predicts kept boxes and compares results
`timescale 1ns / 100ps

module hnms_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] left,
	input  logic [15:0] top,
	input  logic [15:0] right,
	input  logic [15:0] bottom,
	input  logic [15:0] score,
	input  logic        last_box,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        result_valid,
	input  logic [5:0]  box_index,
	input  logic [15:0] out_left,
	input  logic [15:0] out_top,
	input  logic [15:0] out_right,
	input  logic [15:0] out_bottom,
	input  logic [15:0] out_score,
	input  logic        last_pick,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [5:0]  idx;
		logic [15:0] l, t, r, b, s;
		logic        lst;
	} kept_box_t;

	kept_box_t   kept_q[$];
	logic [15:0] bx_l[64], bx_t[64], bx_r[64], bx_b[64], bx_s[64];
	int          stored;
	logic [15:0] iou_thr;
	logic [6:0]  keep_max, cand_max;

	assign pending = kept_q.size();

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic longint unsigned area(input int l, input int t, input int r, input int b);
		longint unsigned w, h;
		w = (r > l) ? r - l : 0;
		h = (b > t) ? b - t : 0;
		return w * h;
	endfunction

	function automatic bit suppressed(input int a, input int p);
		int l, t, r, b;
		longint unsigned ov, den;
		l = (bx_l[a] > bx_l[p]) ? bx_l[a] : bx_l[p];
		t = (bx_t[a] > bx_t[p]) ? bx_t[a] : bx_t[p];
		r = (bx_r[a] < bx_r[p]) ? bx_r[a] : bx_r[p];
		b = (bx_b[a] < bx_b[p]) ? bx_b[a] : bx_b[p];
		ov = area(l, t, r, b);
		den = area(bx_l[a], bx_t[a], bx_r[a], bx_b[a]) + area(bx_l[p], bx_t[p], bx_r[p], bx_b[p])
			- ov + 64'(hnms_pkg::IOU_EPS);
		return (ov << 16) > longint'(iou_thr) * den;
	endfunction

	task automatic predict_kept();
		int order[64];
		bit alive[64];
		int n, cands, picks, j, v;
		kept_box_t k;
		n = stored;
		picks = 0;
		for (int i = 0; i < n; i++) begin
			v = i;
			j = i;
			while (j > 0 && bx_s[order[j-1]] < bx_s[v]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = v;
		end
		cands = (cand_max < n) ? cand_max : n;
		for (int i = 0; i < 64; i++) alive[i] = (i < cands);
		for (int i = 0; i < cands; i++) begin
			if (!alive[i]) continue;
			if (keep_max != 0 && picks >= keep_max) break;
			alive[i] = 0;
			v = order[i];
			k.idx = 6'(v); k.l = bx_l[v]; k.t = bx_t[v]; k.r = bx_r[v]; k.b = bx_b[v];
			k.s = bx_s[v]; k.lst = 1'b0;
			kept_q.insert(kept_q.size(), k);
			picks++;
			for (int m = i + 1; m < cands; m++)
				if (alive[m] && suppressed(order[m], v)) alive[m] = 0;
		end
		if (picks > 0) kept_q[kept_q.size()-1].lst = 1'b1;
		stored = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		kept_box_t k;
		if (!arst_n) begin
			fail_count = 0;
			stored     = 0;
			iou_thr    = hnms_pkg::IOU_THR_RESET;
			keep_max   = hnms_pkg::TOP_K_RESET;
			cand_max   = hnms_pkg::CAND_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hnms_pkg::CFG_IOU_THR: iou_thr  = cfg_data;
					hnms_pkg::CFG_TOP_K:   keep_max = cfg_data[6:0];
					hnms_pkg::CFG_CAND:    cand_max = cfg_data[6:0];
					default: ;
				endcase
			end
			if (result_valid) begin
				if (kept_q.size() == 0) begin
					report("unexpected result, box_index", box_index, 0);
				end else begin
					k = kept_q.pop_front();
					if (box_index !== k.idx) report("box_index", box_index, k.idx);
					if (out_left !== k.l) report("out_left", out_left, k.l);
					if (out_top !== k.t) report("out_top", out_top, k.t);
					if (out_right !== k.r) report("out_right", out_right, k.r);
					if (out_bottom !== k.b) report("out_bottom", out_bottom, k.b);
					if (out_score !== k.s) report("out_score", out_score, k.s);
					if (last_pick !== k.lst) report("last_pick", last_pick, k.lst);
				end
			end
			if (start && !busy) begin
				if (stored < 64) begin
					bx_l[stored] = left; bx_t[stored] = top; bx_r[stored] = right;
					bx_b[stored] = bottom; bx_s[stored] = score;
					stored++;
				end
				if (last_box) predict_kept();
			end
		end
	end

endmodule

// ===== bench/tb_hard_non_max_suppression_core.sv =====
// testbench top for the hard non-max suppression core: stimulus, timeout and verdict
`timescale 1ns / 100ps

module tb_hard_non_max_suppression_core;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [15:0] left = 0, top = 0, right = 0, bottom = 0, score = 0;
	logic        last_box = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = hnms_pkg::CFG_IOU_THR;
	logic [15:0] cfg_data = 0;
	logic        result_valid;
	logic [5:0]  box_index;
	logic [15:0] out_left, out_top, out_right, out_bottom, out_score;
	logic        last_pick;
	int          fail_count, pending, cycles, sent;
	bit          eager;

	hard_non_max_suppression_core dut (.*);
	hnms_checker checker_i (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (eager || r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_box(input int l, t, r, b, s, input bit lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		left <= 16'(l); top <= 16'(t); right <= 16'(r); bottom <= 16'(b); score <= 16'(s);
		last_box <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	task automatic settle();
		start <= 0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		settle();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_cluster(input int n, input bit dup_scores);
		int bx, by, w, h, l, t;
		bx = $urandom_range(0, 60000);
		by = $urandom_range(0, 60000);
		w = $urandom_range(200, 5000);
		h = $urandom_range(200, 5000);
		for (int i = 0; i < n; i++) begin
			l = bx + $urandom_range(0, 600);
			t = by + $urandom_range(0, 600);
			if ($urandom_range(0, 15) == 0)
				send_box(l + w, t, l, t + h, $urandom_range(0, 65535), i == n - 1);
			else
				send_box(l, t, (l + w + $urandom_range(0, 400)) & 16'hffff,
					(t + h + $urandom_range(0, 400)) & 16'hffff,
					dup_scores ? $urandom_range(100, 103) : $urandom_range(0, 65535),
					i == n - 1);
		end
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			send_box($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), i == n - 1);
	endtask

	task automatic random_config();
		int r;
		r = $urandom_range(0, 3);
		write_reg(hnms_pkg::CFG_IOU_THR,
			r == 0 ? 16'hffff : r == 1 ? 16'd0 : 16'($urandom_range(0, 65535)));
		r = $urandom_range(0, 3);
		write_reg(hnms_pkg::CFG_TOP_K,
			{9'($urandom), 7'(r == 0 ? 0 : r == 1 ? 64 : $urandom_range(0, 127))});
		r = $urandom_range(0, 3);
		write_reg(hnms_pkg::CFG_CAND,
			{9'($urandom), 7'(r == 0 ? 64 : r == 1 ? 1 : $urandom_range(1, 127))});
	endtask

	initial begin
		int r;
		sent = 0;
		eager = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings, corner extremes, reversed corners, equal scores, config extremes
		send_box(0, 0, 65535, 65535, 65535, 0);
		send_box(0, 0, 65535, 65535, 65535, 0);
		send_box(65535, 65535, 0, 0, 0, 0);
		send_box(100, 100, 20000, 20000, 30000, 0);
		send_box(120, 110, 20100, 20050, 30000, 1);
		send_box(5, 5, 6, 6, 1, 1);
		write_reg(hnms_pkg::CFG_IOU_THR, 16'hffff);
		write_reg(hnms_pkg::CFG_TOP_K, 16'd0);
		write_reg(hnms_pkg::CFG_CAND, 16'd127);
		send_box(1000, 1000, 3000, 3000, 500, 0);
		send_box(1000, 1000, 3000, 3000, 500, 0);
		send_box(1010, 990, 3010, 2990, 700, 1);
		write_reg(hnms_pkg::CFG_IOU_THR, 16'd0);
		write_reg(hnms_pkg::CFG_TOP_K, 16'd1);
		write_reg(hnms_pkg::CFG_CAND, 16'd1);
		send_box(1000, 1000, 3000, 3000, 500, 0);
		send_box(40000, 40000, 50000, 50000, 900, 1);
		write_reg(hnms_pkg::CFG_TOP_K, 16'd64);
		write_reg(hnms_pkg::CFG_CAND, 16'd0);
		send_box(1000, 1000, 3000, 3000, 500, 0);
		send_box(1000, 1000, 3000, 3000, 600, 1);
		write_reg(hnms_pkg::CFG_IOU_THR, 16'd32768);
		write_reg(hnms_pkg::CFG_CAND, 16'd64);
		write_reg(hnms_pkg::CFG_TOP_K, 16'd0);
		send_box(0, 0, 0, 0, 0, 0);
		send_box(10, 10, 2000, 2000, 65535, 0);
		send_box(2000, 2000, 10, 10, 65535, 1);

		// one set past capacity
		send_cluster(66, 0);

		while (sent < 150) begin
			eager = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0) random_config();
			r = $urandom_range(0, 19);
			if (r < 14) begin
				send_cluster($urandom_range(2, 10), r < 3);
			end else if (r < 18) begin
				send_noise($urandom_range(1, 6));
			end else begin
				send_cluster(1, 0);
			end
			if ($urandom_range(0, 4) == 0) settle();
		end

		settle();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hnms_pkg.sv
rtl/core/hnms_mem.sv
rtl/core/hnms_iou.sv
rtl/core/hard_non_max_suppression_core.sv
bench/hnms_checker.sv
bench/tb_hard_non_max_suppression_core.sv
